>>> rtl/assert_macros.svh
// Assertion macros shared by the linear interpolation stepper RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define LIS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define LIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lis_pkg.sv
// Package: widths, sequencer states and lane control struct of the stepper
`timescale 1ns / 1ps

package lis_pkg;

	localparam int LANE_W        = 24;
	localparam int DIFF_W        = LANE_W + 1;
	localparam int NUM_LANES     = 3;
	localparam int LANE_SEL_W    = 2;
	localparam int COUNT_W       = 7;
	localparam int IDX_W         = 6;
	localparam int MAX_COUNT_DEF = 64;

	typedef logic [LANE_SEL_W-1:0] lane_sel_t;

	localparam lane_sel_t LAST_LANE = lane_sel_t'(NUM_LANES - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_EMIT
	} lis_state_t;

	// Commands from the sequencer to the lane registers
	typedef struct packed {
		logic      load;
		logic      step_wr;
		lane_sel_t lane;
		logic      advance;
	} lis_lane_ctrl_t;

endpackage

>>> rtl/lis_div.sv
// Shared restoring divider: unsigned magnitude by small divisor, one bit per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lis_div #(
	parameter int DIVISOR_W = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lis_pkg::DIFF_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]        divisor,
	output logic                        done,
	output logic [lis_pkg::DIFF_W-1:0]  quotient
);

	localparam int QW    = lis_pkg::DIFF_W;
	localparam int CNT_W = $clog2(QW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [QW-1:0]        quo_q;

	logic [DIVISOR_W:0]   shifted;
	logic [DIVISOR_W+1:0] trial;
	logic                 fits;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		shifted = {rem_q, quo_q[QW-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		fits    = ~trial[DIVISOR_W+1];
	end

	// Control: busy while the quotient bits are shifted in, then a one-cycle done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`LIS_ASSERT_IMPL(a_div_no_restart, start, !busy_q, "divider started while busy")
	`LIS_ASSERT_IMPL(a_div_done_after_busy, done_q, !busy_q && $past(busy_q),
		"divider done without a finished run")

endmodule

>>> rtl/lis_lanes.sv
// Lane registers: position, step and difference for the three components
`timescale 1ns / 1ps

module lis_lanes (
	input  logic                                           clk,
	input  lis_pkg::lis_lane_ctrl_t                        ctrl,
	input  logic [lis_pkg::NUM_LANES-1:0][lis_pkg::LANE_W-1:0] start_v,
	input  logic [lis_pkg::NUM_LANES-1:0][lis_pkg::LANE_W-1:0] end_v,
	input  logic [lis_pkg::DIFF_W-1:0]                     quotient,
	output logic [lis_pkg::DIFF_W-1:0]                     div_mag,
	output logic [lis_pkg::NUM_LANES-1:0][lis_pkg::LANE_W-1:0] pos
);

	localparam int LW = lis_pkg::LANE_W;
	localparam int DW = lis_pkg::DIFF_W;
	localparam int NL = lis_pkg::NUM_LANES;

	logic [LW-1:0] pos_q  [NL];
	logic [LW-1:0] step_q [NL];
	logic [DW-1:0] diff_q [NL];

	logic          sel_neg;
	logic [DW-1:0] sel_diff;
	logic [LW-1:0] step_val;

	// Magnitude of the selected difference feeds the divider; sign fixes the step
	always_comb begin
		sel_diff = diff_q[ctrl.lane];
		sel_neg  = sel_diff[DW-1];
		div_mag  = sel_neg ? (~sel_diff + DW'(1)) : sel_diff;
		step_val = sel_neg ? LW'(~quotient + DW'(1)) : LW'(quotient);
	end

	// Load on accept, write steps as they finish, advance on each taken word but the last
	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			if (ctrl.load) begin
				pos_q[i]  <= start_v[i];
				step_q[i] <= '0;
				diff_q[i] <= {end_v[i][LW-1], end_v[i]} - {start_v[i][LW-1], start_v[i]};
			end else if (ctrl.advance) begin
				pos_q[i] <= pos_q[i] + step_q[i];
			end
		end
		if (ctrl.step_wr) begin
			step_q[ctrl.lane] <= step_val;
		end
	end

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			pos[i] = pos_q[i];
		end
	end

endmodule

>>> rtl/linear_interpolation_stepper_top.sv
// Linear interpolation stepper: top level with the run sequencer
//
// Input channel: start_x/y/z, end_x/y/z (signed Q8.16) and count, handshaked
// by in_valid / in_stall. A word is taken when in_valid is high and in_stall
// is low. count above MAX_COUNT is clamped; count of zero is dropped.
// Output channel: one word per point (out_x/y/z, point_index, last) under
// out_valid / out_stall. last marks the final point of the run.
// Timing: the three per-lane steps come from one shared bit-serial divider,
// run once per lane, so the first point is valid once all three steps are
// written (a count of one skips the divider and goes straight to the points).
// After that one point per cycle while out_stall is low. in_stall stays high
// from an accepted word with a nonzero count until its last point has been
// taken; a word with a count of zero leaves it low.
// A stalled output word holds all fields; the run simply pauses.
// Reset (arst_n low) returns the sequencer to idle and drops any run.

`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_interpolation_stepper_top #(
	parameter int MAX_COUNT = lis_pkg::MAX_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [lis_pkg::LANE_W-1:0] start_x,
	input  logic signed [lis_pkg::LANE_W-1:0] start_y,
	input  logic signed [lis_pkg::LANE_W-1:0] start_z,
	input  logic signed [lis_pkg::LANE_W-1:0] end_x,
	input  logic signed [lis_pkg::LANE_W-1:0] end_y,
	input  logic signed [lis_pkg::LANE_W-1:0] end_z,
	input  logic [lis_pkg::COUNT_W-1:0]       count,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [lis_pkg::LANE_W-1:0] out_x,
	output logic signed [lis_pkg::LANE_W-1:0] out_y,
	output logic signed [lis_pkg::LANE_W-1:0] out_z,
	output logic [lis_pkg::IDX_W-1:0]         point_index,
	output logic                              last
);

	localparam int N_W = $clog2(MAX_COUNT + 1);
	localparam int K_W = $clog2(MAX_COUNT);

	lis_pkg::lis_state_t     state_q, state_d;
	lis_pkg::lis_lane_ctrl_t ctrl;
	lis_pkg::lane_sel_t      lane_q;
	logic [N_W-1:0]          n_q;
	logic [N_W-1:0]          n_sat;
	logic [K_W-1:0]          k_q;
	logic [K_W-1:0]          k_end;

	logic in_acc;
	logic out_acc;
	logic last_pt;
	logic div_start;
	logic div_done;

	logic [lis_pkg::DIFF_W-1:0] div_mag;
	logic [lis_pkg::DIFF_W-1:0] quotient;
	logic [lis_pkg::NUM_LANES-1:0][lis_pkg::LANE_W-1:0] start_v, end_v, pos;

	// Clamp the count and decode the handshakes
	always_comb begin
		n_sat   = (count > lis_pkg::COUNT_W'(MAX_COUNT)) ? N_W'(MAX_COUNT) : N_W'(count);
		in_acc  = in_valid && !in_stall;
		out_acc = out_valid && !out_stall;
		k_end   = K_W'(n_q - N_W'(1));
		last_pt = (k_q == k_end);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lis_pkg::S_IDLE: begin
				if (in_acc && count != '0) begin
					state_d = (n_sat == N_W'(1)) ? lis_pkg::S_EMIT : lis_pkg::S_DIV_GO;
				end
			end
			lis_pkg::S_DIV_GO: begin
				state_d = lis_pkg::S_DIV_WAIT;
			end
			lis_pkg::S_DIV_WAIT: begin
				if (div_done) begin
					state_d = (lane_q == lis_pkg::LAST_LANE) ? lis_pkg::S_EMIT
						: lis_pkg::S_DIV_GO;
				end
			end
			lis_pkg::S_EMIT: begin
				if (out_acc && last_pt) begin
					state_d = lis_pkg::S_IDLE;
				end
			end
			default: state_d = lis_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ctrl      = '0;
		ctrl.lane = lane_q;
		div_start = 1'b0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			lis_pkg::S_IDLE: begin
				in_stall  = 1'b0;
				ctrl.load = in_valid;
			end
			lis_pkg::S_DIV_GO: begin
				div_start = 1'b1;
			end
			lis_pkg::S_DIV_WAIT: begin
				ctrl.step_wr = div_done;
			end
			lis_pkg::S_EMIT: begin
				out_valid    = 1'b1;
				ctrl.advance = !out_stall && !last_pt;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// State, lane and point counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lis_pkg::S_IDLE;
			lane_q  <= '0;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				n_q    <= n_sat;
				lane_q <= '0;
				k_q    <= '0;
			end
			if (ctrl.step_wr) begin
				lane_q <= lane_q + lis_pkg::LANE_SEL_W'(1);
			end
			if (ctrl.advance) begin
				k_q <= k_q + K_W'(1);
			end
		end
	end

	assign start_v = {start_z, start_y, start_x};
	assign end_v   = {end_z, end_y, end_x};

	lis_div #(
		.DIVISOR_W (K_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.divisor  (k_end),
		.done     (div_done),
		.quotient (quotient)
	);

	lis_lanes u_lanes (
		.clk      (clk),
		.ctrl     (ctrl),
		.start_v  (start_v),
		.end_v    (end_v),
		.quotient (quotient),
		.div_mag  (div_mag),
		.pos      (pos)
	);

	assign out_x       = pos[0];
	assign out_y       = pos[1];
	assign out_z       = pos[2];
	assign point_index = lis_pkg::IDX_W'(k_q);
	assign last        = last_pt;

	`LIS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall && count != '0, in_stall,
		"input taken again before the run ended")
	`LIS_ASSERT_IMPL(a_done_only_waiting, div_done, state_q == lis_pkg::S_DIV_WAIT,
		"divider finished outside a step wait")
	`LIS_ASSERT_NEXT(a_run_ends, out_valid && !out_stall && last, !out_valid,
		"output still valid after the last point")
	`LIS_ASSERT_NEXT(a_index_steps, out_valid && !out_stall && !last,
		out_valid && point_index == lis_pkg::IDX_W'($past(point_index) + 1'b1),
		"point index did not advance by one")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the three-lane linear interpolation stepper
`timescale 1ns / 1ps

module testbench;

	localparam int LANE_W      = lis_pkg::LANE_W;
	localparam int COUNT_W     = lis_pkg::COUNT_W;
	localparam int IDX_W       = lis_pkg::IDX_W;
	localparam int MAX_POINTS  = lis_pkg::MAX_COUNT_DEF;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 200;
	localparam int HOLD_LONG   = 400;

	// Receiver behavior
	localparam int SINK_FREE    = 0;
	localparam int SINK_RANDOM  = 1;
	localparam int SINK_PATTERN = 2;

	typedef struct {
		logic signed [LANE_W-1:0] sx, sy, sz;
		logic signed [LANE_W-1:0] ex, ey, ez;
		logic [COUNT_W-1:0]       n;
	} segment_t;

	typedef struct {
		logic signed [LANE_W-1:0] x, y, z;
		logic [IDX_W-1:0]         idx;
		logic                     last;
	} point_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [LANE_W-1:0] start_x, start_y, start_z;
	logic signed [LANE_W-1:0] end_x, end_y, end_z;
	logic [COUNT_W-1:0] count;
	logic out_valid;
	logic out_stall;
	logic signed [LANE_W-1:0] out_x, out_y, out_z;
	logic [IDX_W-1:0] point_index;
	logic last;

	point_t pending_points[$];
	point_t want;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int hold_cycles = 0;
	int sink_mode = SINK_FREE;
	int sink_tick = 0;
	bit gaps_on = 1'b0;
	int burst_left = 0;

	linear_interpolation_stepper_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_x    (start_x),
		.start_y    (start_y),
		.start_z    (start_z),
		.end_x      (end_x),
		.end_y      (end_y),
		.end_z      (end_z),
		.count      (count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.point_index(point_index),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Work out every point of one run: clamp the count, divide once per lane, then add
	function automatic void plan_points(segment_t s);
		int n;
		longint base[3];
		longint target[3];
		longint pos[3];
		longint step[3];
		point_t p;
		n = (s.n > MAX_POINTS) ? MAX_POINTS : int'(s.n);
		if (n == 0)
			return;
		base[0] = s.sx; base[1] = s.sy; base[2] = s.sz;
		target[0] = s.ex; target[1] = s.ey; target[2] = s.ez;
		for (int l = 0; l < 3; l++) begin
			pos[l] = base[l];
			step[l] = (n > 1) ? (target[l] - base[l]) / longint'(n - 1) : 64'sd0;
		end
		for (int k = 0; k < n; k++) begin
			if (k > 0) begin
				for (int l = 0; l < 3; l++)
					pos[l] += step[l];
			end
			p.x = pos[0][LANE_W-1:0];
			p.y = pos[1][LANE_W-1:0];
			p.z = pos[2][LANE_W-1:0];
			p.idx = k[IDX_W-1:0];
			p.last = (k == n - 1);
			pending_points.push_back(p);
		end
	endfunction

	function automatic segment_t make_segment(logic [LANE_W-1:0] sx, logic [LANE_W-1:0] sy,
			logic [LANE_W-1:0] sz, logic [LANE_W-1:0] ex, logic [LANE_W-1:0] ey,
			logic [LANE_W-1:0] ez, logic [COUNT_W-1:0] n);
		segment_t s;
		s.sx = sx; s.sy = sy; s.sz = sz;
		s.ex = ex; s.ey = ey; s.ez = ez;
		s.n = n;
		return s;
	endfunction

	// Pick an end lane: mostly far away, sometimes close to or equal to the start
	function automatic logic [LANE_W-1:0] pick_end(logic [LANE_W-1:0] from);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return LANE_W'($urandom());
		if (r < 9)
			return from + LANE_W'($urandom_range(0, 200)) - LANE_W'(100);
		return from;
	endfunction

	// Count mix: mostly short runs, a few long ones, some zero and over-range
	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		if (r < 60)
			return COUNT_W'($urandom_range(1, 8));
		if (r < 85)
			return COUNT_W'($urandom_range(9, 40));
		if (r < 95)
			return COUNT_W'($urandom_range(41, MAX_POINTS));
		return COUNT_W'($urandom_range(MAX_POINTS + 1, 127));
	endfunction

	function automatic segment_t random_segment();
		segment_t s;
		s.sx = LANE_W'($urandom()); s.sy = LANE_W'($urandom()); s.sz = LANE_W'($urandom());
		s.ex = pick_end(s.sx);
		s.ey = pick_end(s.sy);
		s.ez = pick_end(s.sz);
		s.n = pick_count();
		return s;
	endfunction

	// Hold valid low while idling and scramble the idle payload
	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid = 1'b0;
			start_x = LANE_W'($urandom()); start_y = LANE_W'($urandom());
			start_z = LANE_W'($urandom());
			end_x = LANE_W'($urandom()); end_y = LANE_W'($urandom());
			end_z = LANE_W'($urandom());
			count = COUNT_W'($urandom());
		end
	endtask

	// Offer one word, wait for the handshake, then queue its points
	task automatic send_segment(segment_t s);
		if (gaps_on) begin
			if (burst_left == 0) begin
				idle_cycles($urandom_range(1, 12));
				burst_left = $urandom_range(1, 6);
			end
			burst_left--;
		end
		@(negedge clk);
		start_x = s.sx; start_y = s.sy; start_z = s.sz;
		end_x = s.ex; end_y = s.ey; end_z = s.ez;
		count = s.n;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		plan_points(s);
	endtask

	task automatic test_directed();
		gaps_on = 1'b0;
		sink_mode = SINK_FREE;
		send_segment(make_segment(24'h800000, 24'h7FFFFF, 24'h000000,
			24'h7FFFFF, 24'h800000, 24'h000000, 7'd64));
		send_segment(make_segment(24'h123456, 24'h000000, 24'hFFFFFF,
			24'h654321, 24'h7FFFFF, 24'h800000, 7'd0));
		send_segment(make_segment(24'h7FFFFF, 24'h800000, 24'h010000,
			24'h800000, 24'h7FFFFF, 24'hFF0000, 7'd1));
		send_segment(make_segment(24'h800000, 24'h7FFFFF, 24'h000001,
			24'h7FFFFF, 24'h800000, 24'hFFFFFF, 7'd2));
		// truncation toward zero on negative and positive odd differences
		send_segment(make_segment(24'h000000, 24'h000000, 24'h000000,
			24'hFFFFFB, 24'h000005, 24'h000007, 7'd3));
		send_segment(make_segment(24'h100000, 24'hF00000, 24'h000000,
			24'hF00000, 24'h100000, 24'h00FFFF, 7'd65));
		send_segment(make_segment(24'h800000, 24'h7FFFFF, 24'h555555,
			24'h7FFFFF, 24'h800000, 24'hAAAAAA, 7'd127));
		send_segment(make_segment(24'h3A5C00, 24'hC0FFEE, 24'h800000,
			24'h3A5C00, 24'hC0FFEE, 24'h800000, 7'd10));
		// difference smaller than the step count gives a zero step
		send_segment(make_segment(24'h000000, 24'hFFFFFF, 24'h7FFFFD,
			24'h000003, 24'hFFFFFC, 24'h7FFFFF, 7'd64));
		send_segment(make_segment(24'hAAAAAA, 24'h555555, 24'h0F0F0F,
			24'h555555, 24'hAAAAAA, 24'hF0F0F0, 7'd33));
		send_segment(make_segment(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 7'd0));
		send_segment(make_segment(24'hFFFF00, 24'h0000FF, 24'h800001,
			24'h0000FF, 24'hFFFF00, 24'h7FFFFE, 7'd16));
		send_segment(make_segment(24'h000000, 24'h000000, 24'h000000,
			24'h7FFFFF, 24'h800000, 24'h000000, 7'd4));
	endtask

	task automatic test_random_runs();
		gaps_on = 1'b1;
		for (int i = 0; i < 130; i++) begin
			if (i % 40 == 0)
				sink_mode = (i == 40) ? SINK_PATTERN : SINK_RANDOM;
			send_segment(random_segment());
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		sink_mode = SINK_FREE;
		repeat (12)
			send_segment(random_segment());
	endtask

	// Hold the receiver off for a long stretch while words keep coming
	task automatic test_output_hold();
		gaps_on = 1'b0;
		sink_mode = SINK_RANDOM;
		hold_cycles = HOLD_LONG;
		repeat (5)
			send_segment(random_segment());
	endtask

	// Receiver: long hold when asked, otherwise free, random or patterned stalls
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			sink_tick++;
			if (hold_cycles > 0) begin
				out_stall = 1'b1;
				hold_cycles--;
			end else begin
				case (sink_mode)
					SINK_RANDOM: out_stall = ($urandom_range(0, 3) == 0);
					SINK_PATTERN: out_stall = ((sink_tick % 7) < 3);
					default: out_stall = 1'b0;
				endcase
			end
		end
	end

	// Compare each accepted point with the oldest pending one
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				$error("unexpected point: x=%h y=%h z=%h index=%0d last=%b",
					out_x, out_y, out_z, point_index, last);
				mismatch_count++;
			end else begin
				want = pending_points.pop_front();
				if (out_x !== want.x) begin
					$error("out_x: expected %h, got %h", want.x, out_x);
					mismatch_count++;
				end
				if (out_y !== want.y) begin
					$error("out_y: expected %h, got %h", want.y, out_y);
					mismatch_count++;
				end
				if (out_z !== want.z) begin
					$error("out_z: expected %h, got %h", want.z, out_z);
					mismatch_count++;
				end
				if (point_index !== want.idx) begin
					$error("point_index: expected %0d, got %0d", want.idx, point_index);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: %0d points still pending", pending_points.size());
				$display("[linear_interpolation_stepper_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_x = '0; start_y = '0; start_z = '0;
		end_x = '0; end_y = '0; end_z = '0;
		count = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_runs();
		test_back_to_back();
		test_output_hold();
		idle_cycles(1);

		// Drain, then give a zero-count or late word time to show up
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && pending_points.size() == 0)
			$display("[linear_interpolation_stepper_top] OK");
		else
			$display("[linear_interpolation_stepper_top] ERROR");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/lis_pkg.sv
rtl/lis_div.sv
rtl/lis_lanes.sv
rtl/linear_interpolation_stepper_top.sv
tb/testbench.sv
